// ===== sv/blmr_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blmr_pkg
// Shared constants, codes and helpers for the bounded min/replace list.
// ----------------------------------------------------------------------------
package blmr_pkg;

	localparam int CAPACITY    = 16;
	localparam int IDX_W       = $clog2(CAPACITY);
	localparam int CNT_W       = $clog2(CAPACITY + 1);
	localparam int DATA_W      = 32;
	localparam int CMD_W       = 3;
	localparam int STATUS_W    = 2;
	localparam int COUNT_OUT_W = 5;
	localparam int POS_OUT_W   = 4;

	localparam logic [CMD_W-1:0] CMD_PUSH_FRONT = 3'd0;
	localparam logic [CMD_W-1:0] CMD_PUSH_BACK  = 3'd1;
	localparam logic [CMD_W-1:0] CMD_POP_FRONT  = 3'd2;
	localparam logic [CMD_W-1:0] CMD_REPLACE    = 3'd3;
	localparam logic [CMD_W-1:0] CMD_STATUS     = 3'd4;

	localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

	typedef struct packed {
		logic init;
		logic vld;
		logic first;
		logic repl;
	} blmr_scan_t;

	function automatic logic [IDX_W-1:0] ring_add(input logic [IDX_W-1:0] base,
		input logic [IDX_W-1:0] off);
		logic [IDX_W:0] sum;
		sum = {1'b0, base} + {1'b0, off};
		if (sum >= (IDX_W+1)'(CAPACITY)) begin
			sum = sum - (IDX_W+1)'(CAPACITY);
		end
		return sum[IDX_W-1:0];
	endfunction

endpackage
`default_nettype wire

// ===== sv/blmr_if.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blmr_if
// Command and result channels: valid/ready with payload.
// ----------------------------------------------------------------------------
interface blmr_req_if
	import blmr_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [CMD_W-1:0]         cmd;
	logic signed [DATA_W-1:0] value;
	logic signed [DATA_W-1:0] match_value;

	modport source(output valid, output cmd, output value, output match_value,
		input ready);
	modport sink(input valid, input cmd, input value, input match_value,
		output ready);
endinterface

interface blmr_rsp_if
	import blmr_pkg::*;
;
	logic                     valid;
	logic                     ready;
	logic [STATUS_W-1:0]      status;
	logic [COUNT_OUT_W-1:0]   entry_count;
	logic                     min_valid;
	logic signed [DATA_W-1:0] min_value;
	logic [POS_OUT_W-1:0]     min_position;

	modport source(output valid, output status, output entry_count,
		output min_valid, output min_value, output min_position, input ready);
	modport sink(input valid, input status, input entry_count,
		input min_valid, input min_value, input min_position, output ready);
endinterface
`default_nettype wire

// ===== sv/blmr_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blmr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module blmr_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule
`default_nettype wire

// ===== sv/blmr_min_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// blmr_min_unit
// Shared compare unit: match/replace decision and running signed minimum.
// ----------------------------------------------------------------------------
module blmr_min_unit
	import blmr_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire blmr_scan_t               scan,
	input  wire logic [IDX_W-1:0]         pos,
	input  wire logic signed [DATA_W-1:0] rdata,
	input  wire logic signed [DATA_W-1:0] match_value,
	input  wire logic signed [DATA_W-1:0] value,
	output      logic                     wr_en,
	output      logic signed [DATA_W-1:0] wr_data,
	output      logic signed [DATA_W-1:0] min_value,
	output      logic [IDX_W-1:0]         min_pos
);

	logic                     hit;
	logic signed [DATA_W-1:0] eff;
	logic signed [DATA_W-1:0] min_q;
	logic [IDX_W-1:0]         pos_q;

	assign hit     = scan.repl && (rdata == match_value);
	assign eff     = hit ? value : rdata;
	assign wr_en   = scan.vld && hit;
	assign wr_data = value;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			min_q <= '0;
			pos_q <= '0;
		end else if (scan.init) begin
			min_q <= '0;
			pos_q <= '0;
		end else if (scan.vld && (scan.first || (eff < min_q))) begin
			min_q <= eff;
			pos_q <= pos;
		end
	end

	assign min_value = min_q;
	assign min_pos   = pos_q;

endmodule
`default_nettype wire

// ===== sv/bounded_list_with_min_and_replace.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bounded_list_with_min_and_replace
// Ring-buffer list with push/pop, replace-all and minimum search.
//
// channel  dir  payload
// req      in   cmd, value, match_value
// rsp      out  status, entry_count, min_valid, min_value, min_position
//
// A beat on req reaches its rsp beat after one RAM read per entry (count after
// the command) through the single read port, a drain state for the last read and
// a done state that posts the result; a list that ends empty goes straight to done.
// req is held off while a command runs or a result waits on rsp.
// arst_n clears head, count and control; entry storage is not cleared.
// ----------------------------------------------------------------------------
module bounded_list_with_min_and_replace
	import blmr_pkg::*;
(
	input wire logic clk,
	input wire logic arst_n,
	blmr_req_if.sink   req,
	blmr_rsp_if.source rsp
);

	typedef enum logic [3:0] {
		S_IDLE  = 4'b0001,
		S_SCAN  = 4'b0010,
		S_DRAIN = 4'b0100,
		S_DONE  = 4'b1000
	} state_t;

	state_t                   state_q;
	logic [CMD_W-1:0]         cmd_q;
	logic signed [DATA_W-1:0] value_q;
	logic signed [DATA_W-1:0] match_q;
	logic [IDX_W-1:0]         head_q;
	logic [CNT_W-1:0]         count_q;
	logic [IDX_W-1:0]         idx_q;
	logic [STATUS_W-1:0]      status_q;
	logic                     out_valid_q;
	logic                     rd_vld_s1;
	logic [IDX_W-1:0]         pos_s1;
	logic [IDX_W-1:0]         addr_s1;

	logic                     acc;
	logic                     full;
	logic                     empty;
	logic [IDX_W-1:0]         head_dec;
	logic [IDX_W-1:0]         head_inc;
	logic [IDX_W-1:0]         tail_pos;
	logic [IDX_W-1:0]         head_nxt;
	logic [CNT_W-1:0]         count_nxt;
	logic [STATUS_W-1:0]      status_nxt;
	logic                     push_we;
	logic [IDX_W-1:0]         push_addr;
	logic                     scan_rd;
	logic [IDX_W-1:0]         rd_addr;
	logic                     last_rd;

	blmr_scan_t               scan;
	logic signed [DATA_W-1:0] rdata;
	logic                     unit_we;
	logic signed [DATA_W-1:0] unit_wdata;
	logic signed [DATA_W-1:0] min_value;
	logic [IDX_W-1:0]         min_pos;
	logic                     ram_we;
	logic [IDX_W-1:0]         ram_waddr;
	logic [DATA_W-1:0]        ram_wdata;
	logic [DATA_W-1:0]        ram_rdata;
	logic [31:0]              cnt_ext;
	logic [31:0]              pos_ext;

	assign req.ready = (state_q == S_IDLE) && !out_valid_q;
	assign acc       = req.valid && req.ready;

	assign full     = count_q >= CNT_W'(CAPACITY);
	assign empty    = count_q == '0;
	assign head_dec = (head_q == '0) ? IDX_W'(CAPACITY - 1) : head_q - 1'b1;
	assign head_inc = ring_add(head_q, IDX_W'(1));
	assign tail_pos = ring_add(head_q, count_q[IDX_W-1:0]);

	always_comb begin
		head_nxt   = head_q;
		count_nxt  = count_q;
		status_nxt = ST_DONE;
		push_we    = 1'b0;
		push_addr  = tail_pos;
		case (req.cmd)
			CMD_PUSH_FRONT: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					head_nxt  = head_dec;
					count_nxt = count_q + 1'b1;
					push_we   = 1'b1;
					push_addr = head_dec;
				end
			end
			CMD_PUSH_BACK: begin
				if (full) begin
					status_nxt = ST_FULL;
				end else begin
					count_nxt = count_q + 1'b1;
					push_we   = 1'b1;
				end
			end
			CMD_POP_FRONT: begin
				if (empty) begin
					status_nxt = ST_EMPTY;
				end else begin
					head_nxt  = head_inc;
					count_nxt = count_q - 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	assign scan_rd = state_q == S_SCAN;
	assign rd_addr = ring_add(head_q, idx_q);
	assign last_rd = (CNT_W'(idx_q) + 1'b1) == count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			head_q      <= '0;
			count_q     <= '0;
			idx_q       <= '0;
			status_q    <= ST_DONE;
			out_valid_q <= 1'b0;
			rd_vld_s1   <= 1'b0;
			cmd_q       <= CMD_STATUS;
		end else begin
			rd_vld_s1 <= scan_rd;
			if (rsp.valid && rsp.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (acc) begin
						cmd_q    <= req.cmd;
						head_q   <= head_nxt;
						count_q  <= count_nxt;
						status_q <= status_nxt;
						idx_q    <= '0;
						state_q  <= (count_nxt == '0) ? S_DONE : S_SCAN;
					end
				end
				S_SCAN: begin
					idx_q <= idx_q + 1'b1;
					if (last_rd) begin
						state_q <= S_DRAIN;
					end
				end
				S_DRAIN: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					out_valid_q <= 1'b1;
					state_q     <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			value_q <= req.value;
			match_q <= req.match_value;
		end
		pos_s1  <= idx_q;
		addr_s1 <= rd_addr;
	end

	assign scan.init  = acc;
	assign scan.vld   = rd_vld_s1;
	assign scan.first = pos_s1 == '0;
	assign scan.repl  = cmd_q == CMD_REPLACE;

	assign rdata = $signed(ram_rdata);

	blmr_min_unit u_min (
		.clk         (clk),
		.arst_n      (arst_n),
		.scan        (scan),
		.pos         (pos_s1),
		.rdata       (rdata),
		.match_value (match_q),
		.value       (value_q),
		.wr_en       (unit_we),
		.wr_data     (unit_wdata),
		.min_value   (min_value),
		.min_pos     (min_pos)
	);

	assign ram_we    = (acc && push_we) || unit_we;
	assign ram_waddr = unit_we ? addr_s1 : push_addr;
	assign ram_wdata = unit_we ? unit_wdata : req.value;

	blmr_ram #(
		.WIDTH (DATA_W),
		.DEPTH (CAPACITY)
	) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (scan_rd),
		.raddr (rd_addr),
		.rdata (ram_rdata)
	);

	assign cnt_ext = 32'(count_q);
	assign pos_ext = 32'(min_pos);

	assign rsp.valid        = out_valid_q;
	assign rsp.status       = status_q;
	assign rsp.entry_count  = cnt_ext[COUNT_OUT_W-1:0];
	assign rsp.min_valid    = !empty;
	assign rsp.min_value    = min_value;
	assign rsp.min_position = pos_ext[POS_OUT_W-1:0];

endmodule
`default_nettype wire

// ===== tb/sv/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the bounded ring list with min search and
// replace-all. Commands go in from a backlog through a clocked driver. A
// shadow copy of the list predicts each response. A clocked monitor checks
// every response beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;
	import blmr_pkg::*;

	localparam logic [CMD_W-1:0] CMD_SPARE_FIRST = 3'd5;
	localparam logic [CMD_W-1:0] CMD_SPARE_LAST  = 3'd7;
	localparam logic [DATA_W-1:0] WORD_MIN = 32'h8000_0000;
	localparam logic [DATA_W-1:0] WORD_MAX = 32'h7fff_ffff;
	localparam int QUIET_LIMIT = 5000;
	localparam int RAND_CHUNKS = 30;
	localparam int CHUNK_LEN   = 20;

	typedef struct packed {
		logic [CMD_W-1:0]  cmd;
		logic [DATA_W-1:0] value;
		logic [DATA_W-1:0] match_value;
	} list_cmd_t;

	typedef struct packed {
		logic [STATUS_W-1:0]    status;
		logic [COUNT_OUT_W-1:0] entry_count;
		logic                   min_valid;
		logic [DATA_W-1:0]      min_value;
		logic [POS_OUT_W-1:0]   min_position;
	} list_report_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;

	blmr_req_if req_ch();
	blmr_rsp_if rsp_ch();

	bounded_list_with_min_and_replace DUT (
		.clk(clk),
		.arst_n(arst_n),
		.req(req_ch),
		.rsp(rsp_ch)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// shadow list
	logic signed [DATA_W-1:0] shadow_ring [CAPACITY];
	int shadow_head;
	int shadow_count;

	list_cmd_t    cmd_backlog [$];
	list_report_t reports_due [$];
	list_cmd_t    next_cmd;
	int total_beats;
	int beats_in;
	int reports_seen;
	int err_count;
	int quiet_cycles;

	function automatic list_report_t apply_list_cmd(input logic [CMD_W-1:0] cmd,
		input logic signed [DATA_W-1:0] value, input logic signed [DATA_W-1:0] match_value);
		list_report_t rpt;
		logic signed [DATA_W-1:0] lowest;
		int k;
		int pos;
		rpt = '0;
		rpt.status = ST_DONE;
		case (cmd)
			CMD_PUSH_FRONT, CMD_PUSH_BACK: begin
				if (shadow_count >= CAPACITY) begin
					rpt.status = ST_FULL;
				end else if (cmd == CMD_PUSH_FRONT) begin
					shadow_head = (shadow_head + CAPACITY - 1) % CAPACITY;
					shadow_ring[shadow_head] = value;
					shadow_count++;
				end else begin
					shadow_ring[(shadow_head + shadow_count) % CAPACITY] = value;
					shadow_count++;
				end
			end
			CMD_POP_FRONT: begin
				if (shadow_count == 0) begin
					rpt.status = ST_EMPTY;
				end else begin
					shadow_head = (shadow_head + 1) % CAPACITY;
					shadow_count--;
				end
			end
			CMD_REPLACE: begin
				for (k = 0; k < shadow_count; k++) begin
					if (shadow_ring[(shadow_head + k) % CAPACITY] == match_value) begin
						shadow_ring[(shadow_head + k) % CAPACITY] = value;
					end
				end
			end
			default: ;
		endcase
		pos = 0;
		lowest = '0;
		if (shadow_count > 0) begin
			lowest = shadow_ring[shadow_head];
			for (k = 1; k < shadow_count; k++) begin
				if (shadow_ring[(shadow_head + k) % CAPACITY] < lowest) begin
					lowest = shadow_ring[(shadow_head + k) % CAPACITY];
					pos = k;
				end
			end
			rpt.min_valid = 1'b1;
		end
		rpt.entry_count  = COUNT_OUT_W'(shadow_count);
		rpt.min_value    = lowest;
		rpt.min_position = POS_OUT_W'(pos);
		return rpt;
	endfunction

	// three stages of backpressure: sender light/receiver heavy, swapped, none
	function automatic int idle_pct(input int done, input bit sender);
		if (done < total_beats / 3) begin
			return sender ? 33 : 71;
		end else if (done < 2 * total_beats / 3) begin
			return sender ? 71 : 33;
		end
		return 0;
	endfunction

	function automatic logic [DATA_W-1:0] rand_word();
		logic [DATA_W-1:0] w;
		case ($urandom_range(3))
			0: begin
				case ($urandom_range(3))
					0: w = WORD_MIN;
					1: w = WORD_MAX;
					2: w = '0;
					default: w = '1;
				endcase
			end
			1: w = DATA_W'($signed($urandom_range(4)) - 2);
			default: w = $urandom;
		endcase
		return w;
	endfunction

	task automatic queue_cmd(input logic [CMD_W-1:0] cmd, input logic [DATA_W-1:0] value,
		input logic [DATA_W-1:0] match_value);
		list_cmd_t c;
		c.cmd = cmd;
		c.value = value;
		c.match_value = match_value;
		cmd_backlog.push_back(c);
	endtask

	task automatic report_mismatch(input string msg);
		$display("[%0t] MISMATCH beat %0d: %s", $realtime, reports_seen, msg);
		err_count++;
	endtask

	// driver
	always @(posedge clk) begin
		if (arst_n) begin
			if (req_ch.valid && req_ch.ready) begin
				reports_due.push_back(apply_list_cmd(req_ch.cmd, req_ch.value,
					req_ch.match_value));
				beats_in++;
			end
			if (!req_ch.valid || req_ch.ready) begin
				if (cmd_backlog.size() > 0 && $urandom_range(99) >= idle_pct(beats_in, 1'b1)) begin
					next_cmd = cmd_backlog.pop_front();
					req_ch.valid       <= 1'b1;
					req_ch.cmd         <= next_cmd.cmd;
					req_ch.value       <= next_cmd.value;
					req_ch.match_value <= next_cmd.match_value;
				end else begin
					req_ch.valid <= 1'b0;
				end
			end
		end
	end

	// monitor
	always @(posedge clk) begin
		if (arst_n) begin
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (reports_due.size() == 0) begin
					report_mismatch("response with no command outstanding");
				end else begin
					if (rsp_ch.status !== reports_due[0].status)
						report_mismatch($sformatf("status got %0d exp %0d",
							rsp_ch.status, reports_due[0].status));
					if (rsp_ch.entry_count !== reports_due[0].entry_count)
						report_mismatch($sformatf("entry_count got %0d exp %0d",
							rsp_ch.entry_count, reports_due[0].entry_count));
					if (rsp_ch.min_valid !== reports_due[0].min_valid)
						report_mismatch($sformatf("min_valid got %0d exp %0d",
							rsp_ch.min_valid, reports_due[0].min_valid));
					if (rsp_ch.min_value !== reports_due[0].min_value)
						report_mismatch($sformatf("min_value got %0d exp %0d",
							$signed(rsp_ch.min_value), $signed(reports_due[0].min_value)));
					if (rsp_ch.min_position !== reports_due[0].min_position)
						report_mismatch($sformatf("min_position got %0d exp %0d",
							rsp_ch.min_position, reports_due[0].min_position));
					void'(reports_due.pop_front());
				end
				reports_seen++;
			end
			rsp_ch.ready <= ($urandom_range(99) >= idle_pct(reports_seen, 1'b0));
		end
	end

	// watchdog on stalled handshakes
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= QUIET_LIMIT) begin
				$display("Watchdog: no beat for %0d cycles", QUIET_LIMIT);
				$display("Simulation FAILED");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int i;
		int c;
		int j;
		int push_pct;
		int pick;
		logic [DATA_W-1:0] w;

		req_ch.valid       = 1'b0;
		req_ch.cmd         = CMD_STATUS;
		req_ch.value       = '0;
		req_ch.match_value = '0;
		rsp_ch.ready       = 1'b0;
		shadow_head  = 0;
		shadow_count = 0;
		beats_in     = 0;
		reports_seen = 0;
		err_count    = 0;
		quiet_cycles = 0;

		// empty list corner cases
		queue_cmd(CMD_STATUS, '0, '0);
		queue_cmd(CMD_POP_FRONT, WORD_MAX, WORD_MIN);
		queue_cmd(CMD_REPLACE, '1, '1);
		for (i = CMD_SPARE_FIRST; i <= CMD_SPARE_LAST; i++)
			queue_cmd(CMD_W'(i), '1, '1);
		// fill to capacity with extremes and repeated minima
		for (i = 0; i < CAPACITY; i++) begin
			case (i % 4)
				0: w = WORD_MAX;
				1: w = WORD_MIN;
				2: w = '1;
				default: w = DATA_W'(i);
			endcase
			queue_cmd(i % 2 ? CMD_PUSH_BACK : CMD_PUSH_FRONT, w, '0);
		end
		queue_cmd(CMD_PUSH_FRONT, '0, '0);
		queue_cmd(CMD_PUSH_BACK, WORD_MIN, '0);
		queue_cmd(CMD_REPLACE, WORD_MAX, WORD_MIN);

		// random walk on fill level: push-heavy, balanced and pop-heavy chunks
		for (c = 0; c < RAND_CHUNKS; c++) begin
			case ($urandom_range(2))
				0: push_pct = 85;
				1: push_pct = 50;
				default: push_pct = 15;
			endcase
			for (j = 0; j < CHUNK_LEN; j++) begin
				if ($urandom_range(99) < push_pct) begin
					queue_cmd($urandom_range(1) ? CMD_PUSH_BACK : CMD_PUSH_FRONT,
						rand_word(), $urandom);
				end else begin
					pick = $urandom_range(9);
					if (pick < 6)
						queue_cmd(CMD_POP_FRONT, $urandom, $urandom);
					else if (pick < 8)
						queue_cmd(CMD_REPLACE, rand_word(), rand_word());
					else if (pick < 9)
						queue_cmd(CMD_STATUS, $urandom, $urandom);
					else
						queue_cmd(CMD_W'($urandom_range(CMD_SPARE_LAST, CMD_SPARE_FIRST)),
							$urandom, $urandom);
				end
			end
		end
		total_beats = cmd_backlog.size();

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		while (cmd_backlog.size() != 0 || req_ch.valid || reports_due.size() != 0)
			@(posedge clk);
		repeat (CAPACITY + 8) @(posedge clk);

		if (err_count == 0) begin
			$display("Simulation PASSED");
		end else begin
			$display("Simulation FAILED");
		end
		$finish;
	end

endmodule

// ===== bounded_list_with_min_and_replace.f =====
sv/blmr_pkg.sv
sv/blmr_if.sv
sv/blmr_ram.sv
sv/blmr_min_unit.sv
sv/bounded_list_with_min_and_replace.sv
tb/sv/tb_top.sv
